/* sv/sorted_key_set_insert_find_unit_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key set
// Shared assertion forms, clocked on aclk and quiet while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_SET_INSERT_FIND_UNIT_ASSERT_SVH
`define SORTED_KEY_SET_INSERT_FIND_UNIT_ASSERT_SVH

// Same-cycle implication
`define SKIF_ASSERT_IMPL(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |-> (con)) \
        else $error("sorted key set: same-cycle check failed");

// Next-cycle implication
`define SKIF_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ant) |=> (con)) \
        else $error("sorted key set: next-cycle check failed");

`endif

/* sv/skif_pkg.sv */
// ---------------------------------------------------------------------------
// Sorted key set package
// Key type, stream field layout, opcodes, control and flag structs.
// ---------------------------------------------------------------------------
package skif_pkg;

    localparam int KEY_W   = 23;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;
    localparam int POS_W   = 6;
    localparam int ENT_W   = 7;

    typedef logic [KEY_W-1:0] key_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_FIND   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_DEC
    } skif_state_t;

    // Strobes sent down the row of cells
    typedef struct packed {
        logic cmp;
        logic shift;
    } skif_ctl_t;

    // Per-cell compare result
    typedef struct packed {
        logic lt;
        logic eq;
    } skif_flag_t;

endpackage

/* sv/skif_cell.sv */
// ---------------------------------------------------------------------------
// Sorted key set cell
// Holds one key, compares it against the incoming key and shifts up by one
// place on insert when its key is not smaller than the new one.
// ---------------------------------------------------------------------------
module skif_cell
    import skif_pkg::*;
(
    input  logic       aclk,
    input  skif_ctl_t  ctl,
    input  logic       occ,
    input  key_t       cmp_key,
    input  key_t       new_key,
    input  key_t       left_key,
    input  logic       left_lt,
    output key_t       key_q,
    output skif_flag_t flag_q,
    output logic       boundary
);

    key_t       key_reg;
    key_t       key_next;
    skif_flag_t flag_reg;
    skif_flag_t flag_next;

    always_comb begin
        flag_next = flag_reg;
        key_next  = key_reg;
        if (ctl.cmp) begin
            flag_next.lt = occ && (key_reg < cmp_key);
            flag_next.eq = occ && (key_reg == cmp_key);
        end
        // take the new key at the insert point, the left neighbor above it
        if (ctl.shift && !flag_reg.lt) begin
            key_next = left_lt ? new_key : left_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        flag_reg <= flag_next;
    end

    assign key_q    = key_reg;
    assign flag_q   = flag_reg;
    assign boundary = left_lt && !flag_reg.lt;

endmodule

/* sv/sorted_key_set_insert_find_unit.sv */
// ---------------------------------------------------------------------------
// Sorted key set, insert and find
// Ordered set of unique (category, elem_index, param_type) keys in a row of
// cells; each result word reports hit, rank, entry count and overflow.
// ---------------------------------------------------------------------------
// For each word, on the accepting edge every cell compares its key against
// the new one; on the commit edge that follows, once the output register is
// free, the flags are decoded into the rank, the row shifts by one place on a
// fresh insert and the result is loaded into the output register. A new word
// is taken only once the previous result has left decode. Entries above the
// fill count are never read and need no clearing after reset.
module sorted_key_set_insert_find_unit
    import skif_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // opcode[0], category[2:1], elem_index[18:3], param_type[23:19]
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    // present[0], position[6:1], entries[13:7], overflow[14]
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tvalid,
    input  logic                m_tready
);

    `include "sorted_key_set_insert_find_unit_assert.svh"

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    skif_state_t         state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    key_t                key_reg, key_next;
    logic                op_reg, op_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    key_t                in_key;
    logic                s_acc;
    skif_ctl_t           ctl;
    key_t                cell_key [TABLE_DEPTH];
    skif_flag_t          cell_flag [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] bound;
    logic [TABLE_DEPTH-1:0] eq_vec;
    logic [IDX_W-1:0]    rank;
    logic                hit;
    logic                full;
    logic                ins_ok;
    logic                commit;
    logic                present;
    logic                overflow;
    logic [31:0]         pos_ext;
    logic [31:0]         ent_ext;

    assign in_key = {s_tdata[2:1], s_tdata[18:3], s_tdata[23:19]};
    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // row of cells
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        key_t left_key;
        logic left_lt;
        logic occ;
        if (i == 0) begin : g_first
            assign left_key = key_reg;
            assign left_lt  = 1'b1;
        end else begin : g_rest
            assign left_key = cell_key[i-1];
            assign left_lt  = cell_flag[i-1].lt;
        end
        assign occ       = (CNT_W'(i) < count_reg);
        assign eq_vec[i] = cell_flag[i].eq;
        skif_cell u_cell (
            .aclk     (aclk),
            .ctl      (ctl),
            .occ      (occ),
            .cmp_key  (in_key),
            .new_key  (key_reg),
            .left_key (left_key),
            .left_lt  (left_lt),
            .key_q    (cell_key[i]),
            .flag_q   (cell_flag[i]),
            .boundary (bound[i])
        );
    end

    // one-hot insert point to rank
    always_comb begin
        rank = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (bound[i]) begin
                rank = rank | IDX_W'(i);
            end
        end
    end

    assign hit    = |eq_vec;
    assign full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign commit = (state_reg == ST_DEC) && (!m_valid_reg || m_tready);
    assign ins_ok = (op_reg == OP_INSERT) && !hit && !full;

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        ctl.cmp      = 1'b0;
        ctl.shift    = 1'b0;
        present      = 1'b0;
        overflow     = 1'b0;
        pos_ext      = '0;
        ent_ext      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    ctl.cmp    = 1'b1;
                    key_next   = in_key;
                    op_next    = s_tdata[0];
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                if (commit) begin
                    ctl.shift = ins_ok;
                    if (ins_ok) begin
                        count_next = count_reg + 1'b1;
                    end
                    present  = hit || ins_ok;
                    overflow = (op_reg == OP_INSERT) && !hit && full;
                    if (present) begin
                        pos_ext = 32'(rank);
                    end
                    ent_ext      = 32'(count_next);
                    m_data_next  = {1'b0, overflow, ent_ext[ENT_W-1:0],
                                    pos_ext[POS_W-1:0], present};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg    <= key_next;
        op_reg     <= op_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `SKIF_ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= CNT_W'(TABLE_DEPTH))
    `SKIF_ASSERT_IMPL(a_single_point, state_reg == ST_DEC, $onehot0(bound))
    `SKIF_ASSERT_IMPL(a_hit_unique, state_reg == ST_DEC, $onehot0(eq_vec))
    `SKIF_ASSERT_NEXT(a_count_step, commit && ins_ok,
                      count_reg == $past(count_reg) + 1'b1)
    `SKIF_ASSERT_IMPL(a_ovf_not_present, m_tvalid && m_tdata[14], !m_tdata[0])

endmodule

/* sim/tb_top.sv */
// ---------------------------------------------------------------------------
// Testbench for the sorted key set, insert and find
// Streams insert and find words into the unit and predicts each result word
// from its own sorted table. A short directed run covers the key extremes,
// duplicates and ordering by each key part. Random traffic then fills the
// table, reaches the full-table rejects and keeps probing held and absent
// keys. Idling on either side changes from phase to phase.
// ---------------------------------------------------------------------------
module tb_top
    import skif_pkg::*;
();

    localparam int DEPTH        = 64;
    localparam int N_RANDOM     = 1830;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    // Input word, lowest bit first: opcode, category, elem_index, param_type
    typedef struct packed {
        logic [4:0]  param_type;
        logic [15:0] elem_index;
        logic [1:0]  category;
        logic        opcode;
    } req_word_t;

    // Result word, lowest bit first: present, position, entries, overflow
    typedef struct packed {
        logic             pad;
        logic             overflow;
        logic [ENT_W-1:0] entries;
        logic [POS_W-1:0] position;
        logic             present;
    } rsp_word_t;

    // Key ordering: category most significant
    typedef struct packed {
        logic [1:0]  category;
        logic [15:0] elem_index;
        logic [4:0]  param_type;
    } key_fields_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    sorted_key_set_insert_find_unit #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    req_word_t   pending_q[$];
    rsp_word_t   expected_q[$];
    key_fields_t issued_keys[$];

    // Predicted contents of the table, sorted ascending
    key_fields_t set_keys[DEPTH];
    int unsigned set_count = 0;

    int unsigned idle_pct   = 0;
    int unsigned stall_pct  = 0;
    int unsigned total_items = 0;
    int unsigned sent_cnt   = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned err_cnt    = 0;
    int unsigned rsp_cnt    = 0;
    int unsigned n_insert   = 0;
    int unsigned n_dup      = 0;
    int unsigned n_reject   = 0;
    int unsigned n_find     = 0;
    int unsigned n_hit      = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Rank lookup and sorted insert on the predicted table
    function automatic rsp_word_t lookup_and_insert(req_word_t w);
        key_fields_t k;
        int unsigned rank;
        logic        hit;
        rsp_word_t   r;
        k    = '{category: w.category, elem_index: w.elem_index,
                 param_type: w.param_type};
        rank = 0;
        r    = '0;
        for (int unsigned i = 0; i < set_count; i++) begin
            if (set_keys[i] < k) rank++;
        end
        hit = (rank < set_count) && (set_keys[rank] == k);
        if (w.opcode == OP_INSERT) begin
            n_insert++;
            if (hit) begin
                n_dup++;
                r.present  = 1'b1;
                r.position = rank[POS_W-1:0];
            end else if (set_count >= DEPTH) begin
                n_reject++;
                r.overflow = 1'b1;
            end else begin
                for (int unsigned i = set_count; i > rank; i--) begin
                    set_keys[i] = set_keys[i-1];
                end
                set_keys[rank] = k;
                set_count++;
                r.present  = 1'b1;
                r.position = rank[POS_W-1:0];
            end
        end else begin
            n_find++;
            if (hit) begin
                n_hit++;
                r.present  = 1'b1;
                r.position = rank[POS_W-1:0];
            end
        end
        r.entries = set_count[ENT_W-1:0];
        return r;
    endfunction

    task automatic push_item(logic op, key_fields_t k);
        req_word_t w;
        w = '{param_type: k.param_type, elem_index: k.elem_index,
              category: k.category, opcode: op};
        pending_q.push_back(w);
        if (op == OP_INSERT) issued_keys.push_back(k);
    endtask

    function automatic key_fields_t mk_key(int cat, int idx, int typ);
        key_fields_t k;
        k.category   = cat[1:0];
        k.elem_index = idx[15:0];
        k.param_type = typ[4:0];
        return k;
    endfunction

    // Step one key part by one, so neighbors differ in a single part
    function automatic key_fields_t near_key(key_fields_t k);
        int step;
        step = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 2))
            0: k.param_type = k.param_type + step[4:0];
            1: k.elem_index = k.elem_index + step[15:0];
            default: k.category = k.category + step[1:0];
        endcase
        return k;
    endfunction

    function automatic key_fields_t pick_issued();
        return issued_keys[$urandom_range(0, issued_keys.size() - 1)];
    endfunction

    function automatic key_fields_t pick_fresh();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            return mk_key($urandom_range(0, 1) ? 3 : 0,
                          $urandom_range(0, 1) ? 16'hFFFF : 0,
                          $urandom_range(0, 1) ? 31 : 0);
        end else if (r < 40 && issued_keys.size() > 0) begin
            return near_key(pick_issued());
        end
        return mk_key($urandom_range(0, 3), $urandom_range(0, 16'hFFFF),
                      $urandom_range(0, 31));
    endfunction

    // Driver: present the next word once the current one is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            case (sent_cnt * 4 / total_items)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 61; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 61; end
                default: begin idle_pct = 8; stall_pct = 8; end
            endcase
            if (s_tvalid && s_tready) begin
                expected_q.push_back(lookup_and_insert(req_word_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                    s_tdata  <= pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    sent_cnt++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    task automatic note_mismatch(string what, rsp_word_t want, rsp_word_t got);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch (%s) at word %0d: expected present=%0d pos=%0d ent=%0d ovf=%0d,",
                     what, rsp_cnt, want.present, want.position, want.entries,
                     want.overflow);
            $display("    got present=%0d pos=%0d ent=%0d ovf=%0d",
                     got.present, got.position, got.entries, got.overflow);
        end
    endtask

    // Monitor: check each result word against the oldest prediction
    always @(posedge aclk) begin
        rsp_word_t got;
        rsp_word_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = rsp_word_t'(m_tdata);
                rsp_cnt++;
                if (expected_q.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (got.present !== want.present || got.position !== want.position ||
                        got.entries !== want.entries || got.overflow !== want.overflow) begin
                        note_mismatch("field", want, got);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_cnt, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        // Directed: empty table, ordering by each key part, extremes, duplicates
        push_item(OP_FIND,   mk_key(0, 0, 0));
        push_item(OP_INSERT, mk_key(1, 16'h8000, 16));
        push_item(OP_INSERT, mk_key(3, 16'hFFFF, 31));
        push_item(OP_INSERT, mk_key(0, 0, 0));
        push_item(OP_INSERT, mk_key(1, 16'h8000, 16));
        push_item(OP_FIND,   mk_key(3, 16'hFFFF, 31));
        push_item(OP_FIND,   mk_key(1, 16'h8000, 15));
        push_item(OP_INSERT, mk_key(1, 16'h8000, 15));
        push_item(OP_INSERT, mk_key(1, 16'h7FFF, 31));
        push_item(OP_INSERT, mk_key(0, 16'hFFFF, 31));
        push_item(OP_INSERT, mk_key(2, 0, 0));
        push_item(OP_FIND,   mk_key(0, 0, 0));
        push_item(OP_FIND,   mk_key(3, 16'hFFFF, 31));
        push_item(OP_FIND,   mk_key(3, 16'hFFFF, 30));
        push_item(OP_INSERT, mk_key(2, 16'hAAAA, 21));
        push_item(OP_INSERT, mk_key(1, 16'h5555, 10));
        push_item(OP_FIND,   mk_key(2, 16'hAAAA, 21));
        push_item(OP_FIND,   mk_key(1, 16'h5555, 10));
        push_item(OP_INSERT, mk_key(3, 16'hFFFF, 31));
        push_item(OP_FIND,   mk_key(1, 16'h8000, 17));

        // Random: fill the table gradually, then keep hitting it while full
        for (int n = 0; n < N_RANDOM; n++) begin
            int unsigned sel;
            sel = $urandom_range(0, 99);
            if (sel < 22)
                push_item(OP_INSERT, pick_fresh());
            else if (sel < 42)
                push_item(OP_INSERT, pick_issued());
            else if (sel < 72)
                push_item(OP_FIND, pick_issued());
            else if (sel < 90)
                push_item(OP_FIND, near_key(pick_issued()));
            else
                push_item(OP_FIND, pick_fresh());
        end
        total_items = pending_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for one checked result word per sent word
        while (rsp_cnt < total_items)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d inserts (%0d duplicates, %0d rejected on a full table)",
                 n_insert, n_dup, n_reject);
        $display("and %0d finds (%0d hits); %0d result words checked, %0d keys held",
                 n_find, n_hit, rsp_cnt, set_count);
        if (err_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/skif_pkg.sv
sv/skif_cell.sv
sv/sorted_key_set_insert_find_unit.sv
sim/tb_top.sv
